// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the edge block checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked during reset
`define SEM_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked during reset
`define SEM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, checked through reset as well
`define SEM_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/sem_pkg.sv =====
// ----------------------------------------------------------------------------
// sem_pkg
// Shared types and constants of the Sobel edge magnitude block.
// ----------------------------------------------------------------------------
package sem_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int CFG_RESET      = 1024;

    localparam int PIX_W  = 8;
    localparam int RGB_W  = 3 * PIX_W;
    localparam int CFG_W  = 11;
    localparam int GRAD_W = 11;
    localparam int SUM_W  = 21;
    localparam int ROOT_W = 8;

    localparam logic       REG_FRAME_WIDTH  = 1'b0;
    localparam logic       REG_FRAME_HEIGHT = 1'b1;

    localparam logic [PIX_W-1:0] MAG_MAX   = 8'd255;
    localparam logic [SUM_W-1:0] SAT_LIMIT = 21'd65280;

    typedef struct packed {
        logic       take;
        logic       load_win;
        logic       grad;
        logic       square;
        logic       root_step;
        logic [2:0] root_bit;
        logic       out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic skip;
        logic have;
    } dp_stat_t;

endpackage

// ===== rtl/sem_ctrl.sv =====
// ----------------------------------------------------------------------------
// sem_ctrl
// Sequencer: accept, window load, gradients, squares, root steps, emit.
// ----------------------------------------------------------------------------
module sem_ctrl
    import sem_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  logic     m_tready,
    output logic     m_tvalid,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_LOAD, ST_GRAD, ST_SQUARE, ST_ROOT, ST_EMIT
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] bit_reg, bit_next;
    logic       valid_reg, valid_next;

    always_comb begin
        cmd           = '0;
        state_next    = state_reg;
        bit_next      = bit_reg;
        valid_next    = valid_reg & ~m_tready;
        cmd.root_bit  = bit_reg;
        case (state_reg)
            ST_IDLE: begin
                cmd.take = s_tvalid;
                if (s_tvalid && !stat.skip) state_next = ST_LOAD;
            end
            ST_LOAD: begin
                cmd.load_win = 1'b1;
                state_next   = stat.have ? ST_GRAD : ST_IDLE;
            end
            ST_GRAD: begin
                cmd.grad   = 1'b1;
                state_next = ST_SQUARE;
            end
            ST_SQUARE: begin
                cmd.square = 1'b1;
                bit_next   = 3'd7;
                state_next = ST_ROOT;
            end
            ST_ROOT: begin
                cmd.root_step = 1'b1;
                bit_next      = bit_reg - 3'd1;
                if (bit_reg == 3'd0) state_next = ST_EMIT;
            end
            ST_EMIT: begin
                // hold until the output register is free
                if (!valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    valid_next   = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            bit_reg   <= 3'd0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            bit_reg   <= bit_next;
            valid_reg <= valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = valid_reg;

endmodule

// ===== rtl/sem_datapath.sv =====
// ----------------------------------------------------------------------------
// sem_datapath
// Line stores, 3x3 window, position counters, gradient and root arithmetic.
// ----------------------------------------------------------------------------
module sem_datapath
    import sem_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic             cfg_idx,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic [RGB_W-1:0] s_data,
    input  logic             s_flush,
    input  dp_cmd_t          cmd,
    output dp_stat_t         stat,
    output logic [RGB_W-1:0] out_data,
    output logic             out_last,
    output logic             out_user
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 2);
    localparam int W_RST = (CFG_RESET > MAX_WIDTH) ? MAX_WIDTH : CFG_RESET;
    localparam int H_RST = (CFG_RESET > MAX_HEIGHT) ? MAX_HEIGHT : CFG_RESET;

    logic [CW-1:0] w_reg;
    logic [HW-1:0] h_reg;
    logic [XW-1:0] in_col_reg;
    logic [RW-1:0] in_row_reg;

    logic [RGB_W-1:0] line_a [MAX_WIDTH];
    logic [RGB_W-1:0] line_b [MAX_WIDTH];
    logic [RGB_W-1:0] ca_q, cb_q;

    logic [RGB_W-1:0] win_reg [3][3];
    logic [XW-1:0]    x_reg;
    logic [RGB_W-1:0] pix_reg;
    logic             have_reg;
    logic             ur0_reg, ur2_reg, uc0_reg, uc2_reg;
    logic             row_end_reg, frame_end_reg;

    logic signed [GRAD_W-1:0] gx_reg [3];
    logic signed [GRAD_W-1:0] gy_reg [3];
    logic [SUM_W-1:0]         sum_reg [3];
    logic [ROOT_W-1:0]        root_reg [3];

    logic [RGB_W-1:0] out_data_reg;
    logic             out_last_reg, out_user_reg;

    // position decode for the item on the input
    logic [RW-1:0] h_ext, r_c;
    logic [CW-1:0] c_c, col_inc;
    logic          x_is0, drain, have_c, at_end;
    logic [CFG_W:0] cfg_ext;

    always_comb begin
        h_ext   = RW'(h_reg);
        x_is0   = (in_col_reg == '0);
        drain   = (in_row_reg >= h_ext);
        at_end  = (in_row_reg >= h_ext + RW'(1));
        if (x_is0) begin
            have_c = (in_row_reg >= RW'(2));
            r_c    = in_row_reg - RW'(2);
            c_c    = w_reg - CW'(1);
        end else begin
            have_c = (in_row_reg >= RW'(1));
            r_c    = in_row_reg - RW'(1);
            c_c    = CW'(in_col_reg) - CW'(1);
        end
        have_c    = have_c && (r_c < h_ext);
        col_inc   = CW'(in_col_reg) + CW'(1);
        stat.skip = !drain && s_flush;
        stat.have = have_reg;
        cfg_ext   = {1'b0, cfg_data};
    end

    // configuration and position counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_reg      <= CW'(W_RST);
            h_reg      <= HW'(H_RST);
            in_col_reg <= '0;
            in_row_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_idx)
                REG_FRAME_WIDTH: begin
                    if (cfg_data == '0)
                        w_reg <= CW'(1);
                    else if (32'(cfg_ext) > 32'(MAX_WIDTH))
                        w_reg <= CW'(MAX_WIDTH);
                    else
                        w_reg <= CW'(cfg_data);
                end
                REG_FRAME_HEIGHT: begin
                    if (cfg_data == '0)
                        h_reg <= HW'(1);
                    else if (32'(cfg_ext) > 32'(MAX_HEIGHT))
                        h_reg <= HW'(MAX_HEIGHT);
                    else
                        h_reg <= HW'(cfg_data);
                end
                default: ;
            endcase
            in_col_reg <= '0;
            in_row_reg <= '0;
        end else if (cmd.take && !stat.skip) begin
            if (at_end) begin
                in_col_reg <= '0;
                in_row_reg <= '0;
            end else if (col_inc >= w_reg) begin
                in_col_reg <= '0;
                in_row_reg <= in_row_reg + RW'(1);
            end else begin
                in_col_reg <= XW'(col_inc);
            end
        end
    end

    // per-item registers captured on accept
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_reg <= 1'b0;
        end else if (cmd.take && !stat.skip) begin
            have_reg <= have_c;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take && !stat.skip) begin
            x_reg         <= in_col_reg;
            pix_reg       <= drain ? '0 : s_data;
            ur0_reg       <= (r_c != '0);
            ur2_reg       <= (r_c + RW'(1) < h_ext);
            uc0_reg       <= (c_c != '0);
            uc2_reg       <= (c_c + CW'(1) < w_reg);
            row_end_reg   <= (c_c == w_reg - CW'(1));
            frame_end_reg <= (c_c == w_reg - CW'(1)) && (r_c == h_ext - RW'(1));
        end
    end

    // line stores: read on accept, written back in the cycle after
    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            ca_q <= line_a[in_col_reg];
            cb_q <= line_b[in_col_reg];
        end
        if (cmd.load_win) begin
            line_a[x_reg] <= cb_q;
            line_b[x_reg] <= pix_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    win_reg[i][j] <= '0;
        end else if (cmd.load_win) begin
            for (int i = 0; i < 3; i++) begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
            end
            win_reg[0][2] <= ca_q;
            win_reg[1][2] <= cb_q;
            win_reg[2][2] <= pix_reg;
        end
    end

    // gradients, one lane per colour (lane 0 red)
    logic [GRAD_W-1:0]        v [3][3];
    logic signed [GRAD_W-1:0] gx_c [3];
    logic signed [GRAD_W-1:0] gy_c [3];
    logic                     use_r [3];
    logic                     use_c [3];

    always_comb begin
        use_r[0] = ur0_reg; use_r[1] = 1'b1; use_r[2] = ur2_reg;
        use_c[0] = uc0_reg; use_c[1] = 1'b1; use_c[2] = uc2_reg;
        for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    v[i][j] = (use_r[i] && use_c[j])
                        ? GRAD_W'(win_reg[i][j][k*PIX_W +: PIX_W]) : '0;
            gx_c[k] = $signed((v[0][2] + (v[1][2] << 1) + v[2][2])
                            - (v[0][0] + (v[1][0] << 1) + v[2][0]));
            gy_c[k] = $signed((v[2][0] + (v[2][1] << 1) + v[2][2])
                            - (v[0][0] + (v[0][1] << 1) + v[0][2]));
        end
    end

    logic signed [2*GRAD_W-1:0] sqx [3];
    logic signed [2*GRAD_W-1:0] sqy [3];
    logic [ROOT_W-1:0]          trial [3];
    logic [2*ROOT_W-1:0]        trial_sq [3];
    logic [2*ROOT_W:0]          lim [3];
    logic [PIX_W-1:0]           mag [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            sqx[k]      = gx_reg[k] * gx_reg[k];
            sqy[k]      = gy_reg[k] * gy_reg[k];
            trial[k]    = root_reg[k] | (ROOT_W'(1) << cmd.root_bit);
            trial_sq[k] = trial[k] * trial[k];
            lim[k]      = (2*ROOT_W+1)'(root_reg[k] * root_reg[k])
                        + (2*ROOT_W+1)'(root_reg[k]);
            if (sum_reg[k] > SAT_LIMIT)
                mag[k] = MAG_MAX;
            else if (sum_reg[k] > SUM_W'(lim[k]))
                mag[k] = root_reg[k] + PIX_W'(1);
            else
                mag[k] = root_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < 3; k++) begin
            if (cmd.grad) begin
                gx_reg[k] <= gx_c[k];
                gy_reg[k] <= gy_c[k];
            end
            if (cmd.square) begin
                sum_reg[k]  <= SUM_W'(sqx[k]) + SUM_W'(sqy[k]);
                root_reg[k] <= '0;
            end else if (cmd.root_step && (SUM_W'(trial_sq[k]) <= sum_reg[k])) begin
                root_reg[k] <= trial[k];
            end
        end
        if (cmd.out_load) begin
            out_data_reg <= {mag[2], mag[1], mag[0]};
            out_last_reg <= row_end_reg;
            out_user_reg <= frame_end_reg;
        end
    end

    assign out_data = out_data_reg;
    assign out_last = out_last_reg;
    assign out_user = out_user_reg;

endmodule

// ===== rtl/sobel_edge_magnitude_rgb.sv =====
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_rgb
// Streaming 3x3 Sobel edge magnitude on RGB pixels, zero outside the frame.
// ----------------------------------------------------------------------------
//  channel | direction | contents
//  s_*     | in        | tdata: red, green, blue pixel; tuser: flush filler
//  m_*     | out       | tdata: red, green, blue magnitude; tlast: row end;
//          |           | tuser: frame end
//  cfg_*   | in        | index 0 frame width, index 1 frame height
//
// A flush inside the frame is accepted and dropped; an item that yields no
// result passes accept and load; an item with a result passes accept, load,
// gradients, squares, 8 root steps and emit. The eight-step root search
// runs side by side on the three lanes.
// Reset is synchronous, active low; no clearing pass is needed.
// A stalled result holds only the emit step; the output register lets the
// next transaction be taken while a result waits.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_rgb
    import sem_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic             cfg_idx,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [RGB_W-1:0] s_tdata,   // pix_red, pix_green, pix_blue
    input  logic             s_tuser,   // flush
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [RGB_W-1:0] m_tdata,   // edge_red, edge_green, edge_blue
    output logic             m_tlast,   // row_end
    output logic             m_tuser    // frame_end
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequence each transaction through the datapath
    sem_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .stat     (stat),
        .cmd      (cmd)
    );

    // line stores, window and arithmetic
    sem_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .s_data   (s_tdata),
        .s_flush  (s_tuser),
        .cmd      (cmd),
        .stat     (stat),
        .out_data (m_tdata),
        .out_last (m_tlast),
        .out_user (m_tuser)
    );

endmodule

// ===== rtl/sem_checker.sv =====
// ----------------------------------------------------------------------------
// sem_checker
// Port-level checks on the edge block, attached by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sem_checker
    import sem_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             s_tuser,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [RGB_W-1:0] m_tdata,
    input logic             m_tlast,
    input logic             m_tuser
);

    `SEM_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
    `SEM_ASSERT_NEXT(a_out_stable, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata), "stalled result changed")
    `SEM_ASSERT_IMPLY(a_frame_row, aclk, aresetn, m_tvalid && m_tuser, m_tlast, "frame end without row end")
    `SEM_ASSERT_NEXT(a_busy, aclk, aresetn, s_tvalid && s_tready && !s_tuser, !s_tready, "pixel taken without busy step")
    `SEM_ASSERT_NEXT_ALWAYS(a_reset, aclk, !aresetn, !m_tvalid, "result valid after reset")

endmodule

bind sobel_edge_magnitude_rgb sem_checker u_sem_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
